### hw/rtl/direction_code_window_majority_assert.svh
// Assertion macros shared by the direction-code window majority RTL.
`ifndef DIRECTION_CODE_WINDOW_MAJORITY_ASSERT_SVH
`define DIRECTION_CODE_WINDOW_MAJORITY_ASSERT_SVH

// Plain property, checked on every rising edge outside reset.
`define DCWM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Overlapping implication, checked on every rising edge outside reset.
`define DCWM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/dcwm_pkg.sv
// Types, constants and decode helpers for the direction-code window majority block.
package dcwm_pkg;

  localparam int unsigned CODE_W  = 16;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned ORD_W   = 3;
  localparam int unsigned NUM_ORD = 8;
  localparam int unsigned PQ_W    = 16;
  localparam int unsigned VEC_W   = 16;
  localparam int unsigned SQ_W    = 30;
  localparam int unsigned CNT_MAX = 2047;

  // Select tree: three pair levels, two register stages per level.
  localparam int unsigned TREE_LEVELS = 3;
  localparam int unsigned PAIR_STAGES = 2;
  localparam int unsigned TREE_DEPTH  = TREE_LEVELS * PAIR_STAGES;

  localparam logic signed [VEC_W-1:0] UNIT_Q14 = 16'sd16384;
  localparam logic signed [VEC_W-1:0] DIAG_Q14 = 16'sd11585;

  typedef enum logic [1:0] {
    ENC_ESRI   = 2'd0,
    ENC_GRASS  = 2'd1,
    ENC_SAGA   = 2'd2,
    ENC_KEYPAD = 2'd3
  } enc_e;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef struct packed {
    logic             hit;
    logic [ORD_W-1:0] ord;
  } dec_t;

  typedef struct packed {
    logic                    vld;
    cnt_t [NUM_ORD-1:0]      counts;
    cnt_t                    best;
  } snap_t;

  // One candidate of the select tree: projection p + q/sqrt(2) (doubled).
  typedef struct packed {
    logic                   elig;
    logic [ORD_W-1:0]       idx;
    logic signed [PQ_W-1:0] p;
    logic signed [PQ_W-1:0] q;
  } cand_t;

  typedef struct packed {
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
  } vec_t;

  // Compass axes, north first, clockwise.
  localparam logic signed [1:0] AXIS_X [NUM_ORD] =
    '{2'sd0, 2'sd1, 2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1};
  localparam logic signed [1:0] AXIS_Y [NUM_ORD] =
    '{2'sd1, 2'sd1, 2'sd0, -2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd1};

  function automatic dec_t decode_code(enc_e enc, logic signed [CODE_W-1:0] code);
    dec_t              d;
    logic [CODE_W-1:0] mag;
    d   = '{hit: 1'b1, ord: '0};
    mag = code[CODE_W-1] ? CODE_W'(-code) : code;
    case (enc)
      ENC_ESRI: begin
        case (code)
          16'sd64:  d.ord = 3'd0;
          16'sd128: d.ord = 3'd1;
          16'sd1:   d.ord = 3'd2;
          16'sd2:   d.ord = 3'd3;
          16'sd4:   d.ord = 3'd4;
          16'sd8:   d.ord = 3'd5;
          16'sd16:  d.ord = 3'd6;
          16'sd32:  d.ord = 3'd7;
          default:  d.hit = 1'b0;
        endcase
      end
      ENC_GRASS: begin
        // -32768 has no 16-bit magnitude below 32768 and falls to default
        case (mag)
          16'd2:   d.ord = 3'd0;
          16'd1:   d.ord = 3'd1;
          16'd8:   d.ord = 3'd2;
          16'd7:   d.ord = 3'd3;
          16'd6:   d.ord = 3'd4;
          16'd5:   d.ord = 3'd5;
          16'd4:   d.ord = 3'd6;
          16'd3:   d.ord = 3'd7;
          default: d.hit = 1'b0;
        endcase
      end
      ENC_SAGA: begin
        if (code inside {[16'sd0:16'sd7]}) begin
          d.ord = code[ORD_W-1:0];
        end else begin
          d.hit = 1'b0;
        end
      end
      ENC_KEYPAD: begin
        case (code)
          16'sd8:  d.ord = 3'd0;
          16'sd9:  d.ord = 3'd1;
          16'sd6:  d.ord = 3'd2;
          16'sd3:  d.ord = 3'd3;
          16'sd2:  d.ord = 3'd4;
          16'sd1:  d.ord = 3'd5;
          16'sd4:  d.ord = 3'd6;
          16'sd7:  d.ord = 3'd7;
          default: d.hit = 1'b0;
        endcase
      end
      default: d.hit = 1'b0;
    endcase
    return d;
  endfunction

  // s is -1, 0 or +1: no multiplier needed.
  function automatic logic signed [PQ_W-1:0] axis_mul(logic signed [1:0] s,
                                                      logic signed [PQ_W-1:0] v);
    logic signed [PQ_W-1:0] r;
    if (s == 2'sd0) begin
      r = '0;
    end else if (s[1]) begin
      r = -v;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic vec_t dir_vec(logic [ORD_W-1:0] idx);
    vec_t                    v;
    logic signed [VEC_W-1:0] m;
    m   = idx[0] ? DIAG_Q14 : UNIT_Q14;
    v.x = axis_mul(AXIS_X[idx], m);
    v.y = axis_mul(AXIS_Y[idx], m);
    return v;
  endfunction

endpackage

### hw/rtl/dcwm_counter.sv
// Input register, code decode and per-window ordinal counting.
module dcwm_counter #(
  parameter int unsigned MAX_WINDOW_CELLS = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [dcwm_pkg::CODE_W-1:0] code_i,
  input  logic                              code_valid_i,
  input  logic                              last_i,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_wdata_i,
  output dcwm_pkg::snap_t                   snap_o
);
  import dcwm_pkg::*;

  localparam int unsigned CapInt = (MAX_WINDOW_CELLS < CNT_MAX) ? MAX_WINDOW_CELLS : CNT_MAX;
  localparam cnt_t        CntCap = CNT_W'(CapInt);

  enc_e                      enc_q;
  logic                      item_vld_q;
  logic signed [CODE_W-1:0]  code_q;
  logic                      cvld_q;
  logic                      last_q;

  cnt_t [NUM_ORD-1:0]        counts_q, counts_d;
  cnt_t                      best_q, best_d;
  cnt_t                      hit_cnt;

  logic                      snap_vld_q;
  cnt_t [NUM_ORD-1:0]        snap_cnt_q;
  cnt_t                      snap_best_q;

  dec_t                      dec;
  logic                      hit;
  logic                      close_win;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q <= ENC_ESRI;
    end else if (cfg_we_i) begin
      enc_q <= enc_e'(cfg_wdata_i);
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
    end else begin
      item_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      code_q <= code_i;
      cvld_q <= code_valid_i;
      last_q <= last_i;
    end
  end

  always_comb begin
    dec       = decode_code(enc_q, code_q);
    hit       = item_vld_q && cvld_q && dec.hit;
    close_win = item_vld_q && last_q;
    counts_d  = counts_q;
    best_d    = best_q;
    hit_cnt   = counts_q[dec.ord];
    if (hit) begin
      if (hit_cnt < CntCap) begin
        hit_cnt = hit_cnt + 1'b1;
      end
      counts_d[dec.ord] = hit_cnt;
      if (hit_cnt > best_q) begin
        best_d = hit_cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q   <= '0;
      best_q     <= '0;
      snap_vld_q <= 1'b0;
    end else begin
      snap_vld_q <= close_win;
      if (close_win) begin
        counts_q <= '0;
        best_q   <= '0;
      end else begin
        counts_q <= counts_d;
        best_q   <= best_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (close_win) begin
      snap_cnt_q  <= counts_d;
      snap_best_q <= best_d;
    end
  end

  assign snap_o = '{vld: snap_vld_q, counts: snap_cnt_q, best: snap_best_q};

endmodule

### hw/rtl/dcwm_projection.sv
// Resultant vector and per-ordinal projection terms of a closed window.
module dcwm_projection (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  dcwm_pkg::snap_t                        snap_i,
  output logic                                   vld_o,
  output dcwm_pkg::cand_t [dcwm_pkg::NUM_ORD-1:0] cands_o
);
  import dcwm_pkg::*;

  logic signed [PQ_W-1:0]  cs [NUM_ORD];
  logic signed [PQ_W-1:0]  xi, xd, yi, yd;
  logic signed [PQ_W-1:0]  di [NUM_ORD];
  logic signed [PQ_W-1:0]  dd [NUM_ORD];
  cand_t [NUM_ORD-1:0]     cands_d, cands_q;
  logic                    vld_q;

  always_comb begin
    for (int k = 0; k < NUM_ORD; k++) begin
      cs[k] = PQ_W'(snap_i.counts[k]);
    end
    // resultant = (xi + xd/sqrt2, yi + yd/sqrt2)
    xi = cs[2] - cs[6];
    xd = cs[1] + cs[3] - cs[5] - cs[7];
    yi = cs[0] - cs[4];
    yd = cs[1] + cs[7] - cs[3] - cs[5];
    for (int k = 0; k < NUM_ORD; k++) begin
      di[k] = axis_mul(AXIS_X[k], xi) + axis_mul(AXIS_Y[k], yi);
      dd[k] = axis_mul(AXIS_X[k], xd) + axis_mul(AXIS_Y[k], yd);
      cands_d[k].idx  = ORD_W'(k);
      cands_d[k].elig = (snap_i.best != '0) && (snap_i.counts[k] == snap_i.best);
      if (k % 2 == 1) begin
        cands_d[k].p = dd[k];
        cands_d[k].q = {di[k][PQ_W-2:0], 1'b0};
      end else begin
        cands_d[k].p = {di[k][PQ_W-2:0], 1'b0};
        cands_d[k].q = {dd[k][PQ_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= snap_i.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_i.vld) begin
      cands_q <= cands_d;
    end
  end

  assign vld_o   = vld_q;
  assign cands_o = cands_q;

endmodule

### hw/rtl/dcwm_pair_cmp.sv
// Two-stage exact compare of two candidates; left wins an exact tie.
module dcwm_pair_cmp (
  input  logic            clk_i,
  input  dcwm_pkg::cand_t left_i,
  input  dcwm_pkg::cand_t right_i,
  output dcwm_pkg::cand_t win_o
);
  import dcwm_pkg::*;

  logic signed [PQ_W:0]     a, b;
  logic signed [2*PQ_W+1:0] a_sq, b_sq;

  cand_t                    l_q, r_q, win_q;
  logic [SQ_W-1:0]          sq2a_q, sqb_q;
  logic                     a_pos_q, a_neg_q, b_neg_q;
  logic                     gt;

  // right beats left when a*sqrt2 > b, a = pr - pl, b = ql - qr
  always_comb begin
    a    = (PQ_W+1)'(right_i.p) - (PQ_W+1)'(left_i.p);
    b    = (PQ_W+1)'(left_i.q) - (PQ_W+1)'(right_i.q);
    a_sq = a * a;
    b_sq = b * b;
  end

  always_ff @(posedge clk_i) begin
    l_q     <= left_i;
    r_q     <= right_i;
    sq2a_q  <= {a_sq[SQ_W-2:0], 1'b0};
    sqb_q   <= b_sq[SQ_W-1:0];
    a_pos_q <= (a > 0);
    a_neg_q <= a[PQ_W];
    b_neg_q <= b[PQ_W];
  end

  always_comb begin
    if (!a_neg_q && b_neg_q) begin
      gt = 1'b1;
    end else if (!a_pos_q && !b_neg_q) begin
      gt = 1'b0;
    end else if (a_pos_q) begin
      gt = sq2a_q > sqb_q;
    end else begin
      gt = sq2a_q < sqb_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!r_q.elig) begin
      win_q <= l_q;
    end else if (!l_q.elig) begin
      win_q <= r_q;
    end else begin
      win_q <= gt ? r_q : l_q;
    end
  end

  assign win_o = win_q;

endmodule

### hw/rtl/direction_code_window_majority.sv
// Top level of the direction-code window majority filter.
//
// Usage: cells of one window enter on start_i with code_i, code_valid_i and
// last_i; a transaction is taken at each rising edge with start_i high and
// busy_o low. busy_o is always low: the counter takes one cell per cycle and
// a closing cell hands its counts to a separate select pipeline, so the next
// window may start on the very next cycle.
// Each window's last cell yields exactly one result on found_o, ordinal_o,
// dir_x_o and dir_y_o, marked by done_o for one cycle; the receiver cannot
// stall, and the result is taken at the edge ending that cycle.
// The path from the last cell to the result runs through the input register,
// count update, projection, three compare levels of two stages each and the
// result register. Throughput: one cell per cycle, so one result per cycle
// for back-to-back one-cell windows.
// The encoding register is written by cfg_we_i / cfg_wdata_i and applies to
// cells taken after the write.
// Reset clears the counts, the pipeline valids and sets encoding to 0 (esri);
// results in flight are dropped.
module direction_code_window_majority #(
  parameter int unsigned MAX_WINDOW_CELLS = 1024
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start_i,
  output logic                               busy_o,
  input  logic signed [dcwm_pkg::CODE_W-1:0] code_i,
  input  logic                               code_valid_i,
  input  logic                               last_i,
  input  logic                               cfg_we_i,
  input  logic [1:0]                         cfg_wdata_i,
  output logic                               done_o,
  output logic                               found_o,
  output logic [dcwm_pkg::ORD_W-1:0]         ordinal_o,
  output logic signed [dcwm_pkg::VEC_W-1:0]  dir_x_o,
  output logic signed [dcwm_pkg::VEC_W-1:0]  dir_y_o
);
  import dcwm_pkg::*;

  `include "direction_code_window_majority_assert.svh"

  snap_t                   snap;
  logic                    proj_vld;
  cand_t [NUM_ORD-1:0]     cands;
  cand_t [3:0]             win_l1;
  cand_t [1:0]             win_l2;
  cand_t                   win_l3;

  logic [TREE_DEPTH-1:0]   vld_pipe_q;

  logic                    done_q;
  logic                    found_q;
  logic [ORD_W-1:0]        ordinal_q;
  vec_t                    vec_q;
  vec_t                    vec_d;

  assign busy_o = 1'b0;

  dcwm_counter #(
    .MAX_WINDOW_CELLS (MAX_WINDOW_CELLS)
  ) u_counter (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .code_i       (code_i),
    .code_valid_i (code_valid_i),
    .last_i       (last_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .snap_o       (snap)
  );

  dcwm_projection u_projection (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .snap_i  (snap),
    .vld_o   (proj_vld),
    .cands_o (cands)
  );

  // Tournament over the eight ordinals; lower ordinals sit on the left side
  // so an exact tie keeps the lowest one.
  for (genvar g = 0; g < 4; g++) begin : g_l1
    dcwm_pair_cmp u_cmp (
      .clk_i   (clk_i),
      .left_i  (cands[2*g]),
      .right_i (cands[2*g+1]),
      .win_o   (win_l1[g])
    );
  end

  for (genvar g = 0; g < 2; g++) begin : g_l2
    dcwm_pair_cmp u_cmp (
      .clk_i   (clk_i),
      .left_i  (win_l1[2*g]),
      .right_i (win_l1[2*g+1]),
      .win_o   (win_l2[g])
    );
  end

  dcwm_pair_cmp u_cmp_l3 (
    .clk_i   (clk_i),
    .left_i  (win_l2[0]),
    .right_i (win_l2[1]),
    .win_o   (win_l3)
  );

  // Valid tracking alongside the select tree
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_pipe_q <= '0;
      done_q     <= 1'b0;
    end else begin
      vld_pipe_q <= {vld_pipe_q[TREE_DEPTH-2:0], proj_vld};
      done_q     <= vld_pipe_q[TREE_DEPTH-1];
    end
  end

  // An eligible winner exists exactly when the window had a valid, decodable cell.
  always_comb begin
    vec_d = win_l3.elig ? dir_vec(win_l3.idx) : '0;
  end

  always_ff @(posedge clk_i) begin
    if (vld_pipe_q[TREE_DEPTH-1]) begin
      found_q   <= win_l3.elig;
      ordinal_q <= win_l3.elig ? win_l3.idx : '0;
      vec_q     <= vec_d;
    end
  end

  assign done_o    = done_q;
  assign found_o   = found_q;
  assign ordinal_o = ordinal_q;
  assign dir_x_o   = vec_q.x;
  assign dir_y_o   = vec_q.y;

  `DCWM_ASSERT(a_last_gives_result, (start_i && !busy_o && last_i) |-> ##10 done_o, "last cell without result")
  `DCWM_ASSERT_IMPL(a_empty_zero, done_o && !found_o, ordinal_o == '0 && dir_x_o == '0 && dir_y_o == '0, "empty window result not zero")
  `DCWM_ASSERT_IMPL(a_vec_matches_ord, done_o && found_o, ordinal_o[0] == (dir_x_o != '0 && dir_y_o != '0) && (dir_x_o != '0 || dir_y_o != '0), "vector does not match ordinal")

endmodule
